// File: hdl/sma_pkg.sv
package sma_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int DEPTH_W     = 7;
	localparam int OP_W        = 4;
	localparam int STAT_W      = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_DEPTH);

	localparam logic [OP_W-1:0] OP_CONST = OP_W'(0);
	localparam logic [OP_W-1:0] OP_ADD   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_SUB   = OP_W'(2);
	localparam logic [OP_W-1:0] OP_MUL   = OP_W'(3);
	localparam logic [OP_W-1:0] OP_DIV   = OP_W'(4);
	localparam logic [OP_W-1:0] OP_MAX   = OP_W'(5);
	localparam logic [OP_W-1:0] OP_MIN   = OP_W'(6);
	localparam logic [OP_W-1:0] OP_NEG   = OP_W'(7);
	localparam logic [OP_W-1:0] OP_DUP   = OP_W'(8);
	localparam logic [OP_W-1:0] OP_SWAP  = OP_W'(9);

	localparam logic [STAT_W-1:0] ST_OK        = STAT_W'(0);
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = STAT_W'(1);
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = STAT_W'(2);
	localparam logic [STAT_W-1:0] ST_DIVZERO   = STAT_W'(3);

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_LOAD
	} cell_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0]          req_type;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [DEPTH_W-1:0]       stack_depth;
		logic [STAT_W-1:0]        status;
	} rsp_t;

endpackage

// File: hdl/stack_machine_alu.sv
// channel  | signals                        | moves
// ---------+--------------------------------+---------------------------------
// request  | req_valid, req_ready, req      | one instruction per transfer
// response | rsp_valid, rsp_ready, rsp      | top, depth, status per instruction
// config   | cfg_we, cfg_data               | stack_limit, written at once
//
// All instructions but a divide have their response registered in the cycle after they are taken;
// a divide that goes ahead waits for the bit-serial divider (32 steps plus start and finish).
// The stack is a row of shift cells; the top two cells feed the ALU.
// Reset clears depth, limit (to the maximum) and the response register.
// A new request is taken while a response waits, provided it is taken too.
module stack_machine_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  sma_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output sma_pkg::rsp_t                 rsp,
	input  logic                          cfg_we,
	input  logic [sma_pkg::DEPTH_W-1:0]   cfg_data
);

	localparam int N = sma_pkg::STACK_DEPTH;
	localparam int W = sma_pkg::DATA_W;
	localparam int DW = sma_pkg::DEPTH_W;

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	state_t                state_q;
	logic [DW-1:0]         count_q;
	logic [DW-1:0]         limit_q;
	logic                  rsp_valid_q;
	sma_pkg::rsp_t         rsp_q;

	logic [W-1:0]          cell_val [N];
	sma_pkg::cell_cmd_t    cmd0, cmd1, cmd_rest;
	logic [W-1:0]          c0_upper, c0_load;

	logic                  accept, div_start, div_done, out_load;
	logic [W-1:0]          a_val, b_val, div_q, alu_r;
	logic [DW-1:0]         lim_eff, cnt_nxt;
	logic [sma_pkg::STAT_W-1:0] stat_nxt;
	logic [W-1:0]          top_nxt;
	logic                  has1, has2, full;

	assign a_val = cell_val[0];
	assign b_val = cell_val[1];

	assign lim_eff = (limit_q == '0) ? DW'(1) :
	                 (limit_q > sma_pkg::DEPTH_MAX) ? sma_pkg::DEPTH_MAX : limit_q;
	assign has1 = (count_q != '0);
	assign has2 = (count_q > DW'(1));
	assign full = (count_q >= lim_eff);

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	always_comb begin
		case (req.req_type)
			sma_pkg::OP_ADD: alu_r = a_val + b_val;
			sma_pkg::OP_SUB: alu_r = a_val - b_val;
			sma_pkg::OP_MUL: alu_r = a_val * b_val;
			sma_pkg::OP_MAX: alu_r = ($signed(b_val) < $signed(a_val)) ? a_val : b_val;
			sma_pkg::OP_MIN: alu_r = ($signed(a_val) < $signed(b_val)) ? a_val : b_val;
			default:         alu_r = a_val;
		endcase
	end

	always_comb begin
		cmd0      = sma_pkg::CELL_HOLD;
		cmd1      = sma_pkg::CELL_HOLD;
		cmd_rest  = sma_pkg::CELL_HOLD;
		c0_upper  = req.push_value;
		c0_load   = alu_r;
		cnt_nxt   = count_q;
		stat_nxt  = sma_pkg::ST_OK;
		top_nxt   = has1 ? a_val : '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		if (state_q == S_DIV) begin
			if (div_done) begin
				cmd0     = sma_pkg::CELL_LOAD;
				cmd1     = sma_pkg::CELL_POP;
				cmd_rest = sma_pkg::CELL_POP;
				c0_load  = div_q;
				cnt_nxt  = count_q - DW'(1);
				top_nxt  = div_q;
				out_load = 1'b1;
			end
		end else if (accept) begin
			out_load = 1'b1;
			case (req.req_type)
				sma_pkg::OP_CONST, sma_pkg::OP_DUP: begin
					if (req.req_type == sma_pkg::OP_DUP && !has1) begin
						stat_nxt = sma_pkg::ST_UNDERFLOW;
					end else if (full) begin
						stat_nxt = sma_pkg::ST_OVERFLOW;
					end else begin
						if (req.req_type == sma_pkg::OP_DUP)
							c0_upper = a_val;
						cmd0     = sma_pkg::CELL_PUSH;
						cmd1     = sma_pkg::CELL_PUSH;
						cmd_rest = sma_pkg::CELL_PUSH;
						cnt_nxt  = count_q + DW'(1);
						top_nxt  = c0_upper;
					end
				end
				sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL,
				sma_pkg::OP_MAX, sma_pkg::OP_MIN: begin
					if (!has2) begin
						stat_nxt = sma_pkg::ST_UNDERFLOW;
					end else begin
						cmd0     = sma_pkg::CELL_LOAD;
						cmd1     = sma_pkg::CELL_POP;
						cmd_rest = sma_pkg::CELL_POP;
						cnt_nxt  = count_q - DW'(1);
						top_nxt  = alu_r;
					end
				end
				sma_pkg::OP_DIV: begin
					if (!has2) begin
						stat_nxt = sma_pkg::ST_UNDERFLOW;
					end else if (b_val == '0) begin
						stat_nxt = sma_pkg::ST_DIVZERO;
					end else begin
						div_start = 1'b1;
						out_load  = 1'b0;
					end
				end
				sma_pkg::OP_NEG: begin
					if (!has1) begin
						stat_nxt = sma_pkg::ST_UNDERFLOW;
					end else begin
						cmd0    = sma_pkg::CELL_LOAD;
						c0_load = W'(0) - a_val;
						top_nxt = c0_load;
					end
				end
				sma_pkg::OP_SWAP: begin
					if (!has2) begin
						stat_nxt = sma_pkg::ST_UNDERFLOW;
					end else begin
						cmd0    = sma_pkg::CELL_LOAD;
						cmd1    = sma_pkg::CELL_LOAD;
						c0_load = b_val;
						top_nxt = b_val;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// top of stack lives in cell 0; cell 1 takes cell 0 on a swap
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [W-1:0]       upper_i, lower_i, load_i;
		sma_pkg::cell_cmd_t cmd_i;

		if (i == 0) begin : g_top
			assign upper_i = c0_upper;
			assign load_i  = c0_load;
			assign cmd_i   = cmd0;
		end else if (i == 1) begin : g_next
			assign upper_i = cell_val[i-1];
			assign load_i  = cell_val[0];
			assign cmd_i   = cmd1;
		end else begin : g_rest
			assign upper_i = cell_val[i-1];
			assign load_i  = '0;
			assign cmd_i   = cmd_rest;
		end

		if (i == N - 1) begin : g_end
			assign lower_i = '0;
		end else begin : g_mid
			assign lower_i = cell_val[i+1];
		end

		sma_cell u_cell (
			.clk      (clk),
			.cmd      (cmd_i),
			.upper    (upper_i),
			.lower    (lower_i),
			.load_val (load_i),
			.val      (cell_val[i])
		);
	end

	sma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_val[W-1] ? (W'(0) - a_val) : a_val),
		.divisor  (b_val[W-1] ? (W'(0) - b_val) : b_val),
		.negate   (a_val[W-1] ^ b_val[W-1]),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			limit_q     <= sma_pkg::DEPTH_MAX;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_data;
			count_q <= cnt_nxt;
			case (state_q)
				S_IDLE:  if (div_start) state_q <= S_DIV;
				S_DIV:   if (div_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (out_load) begin
				rsp_valid_q       <= 1'b1;
				rsp_q.top_value   <= top_nxt;
				rsp_q.stack_depth <= cnt_nxt;
				rsp_q.status      <= stat_nxt;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/sma_cell.sv
module sma_cell (
	input  logic                         clk,
	input  sma_pkg::cell_cmd_t           cmd,
	input  logic [sma_pkg::DATA_W-1:0]   upper,
	input  logic [sma_pkg::DATA_W-1:0]   lower,
	input  logic [sma_pkg::DATA_W-1:0]   load_val,
	output logic [sma_pkg::DATA_W-1:0]   val
);

	logic [sma_pkg::DATA_W-1:0] val_q;

	// upper is the neighbour nearer the top, lower the one further down
	always_ff @(posedge clk) begin
		case (cmd)
			sma_pkg::CELL_PUSH: val_q <= upper;
			sma_pkg::CELL_POP:  val_q <= lower;
			sma_pkg::CELL_LOAD: val_q <= load_val;
			default:            val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// File: hdl/sma_div.sv
module sma_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sma_pkg::DATA_W-1:0]   dividend,
	input  logic [sma_pkg::DATA_W-1:0]   divisor,
	input  logic                         negate,
	output logic                         done,
	output logic [sma_pkg::DATA_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(sma_pkg::DATA_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(sma_pkg::DATA_W - 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [sma_pkg::DATA_W-1:0]   rem_q;
	logic [sma_pkg::DATA_W-1:0]   quo_q;
	logic [sma_pkg::DATA_W-1:0]   dvs_q;
	logic                         neg_q;
	logic [sma_pkg::DATA_W:0]     rem_sh;
	logic [sma_pkg::DATA_W:0]     diff;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[sma_pkg::DATA_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			neg_q <= negate;
		end else if (busy_q) begin
			if (!diff[sma_pkg::DATA_W]) begin
				rem_q <= diff[sma_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sma_pkg::DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[sma_pkg::DATA_W-1:0];
				quo_q <= {quo_q[sma_pkg::DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (sma_pkg::DATA_W'(0) - quo_q) : quo_q;

endmodule

// File: hdl/sma_checker.sv
module sma_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sma_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.stack_depth <= sma_pkg::DEPTH_MAX)
		else $error("depth beyond stack size");

	a_underflow_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sma_pkg::ST_UNDERFLOW |-> rsp.stack_depth < 7'd2)
		else $error("underflow reported with two or more entries");

	a_divzero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == sma_pkg::ST_DIVZERO |-> rsp.stack_depth >= 7'd2)
		else $error("divide by zero reported without two operands");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.stack_depth == 7'd0 |-> rsp.top_value == 32'sd0)
		else $error("empty stack with nonzero top");

endmodule

bind stack_machine_alu sma_checker u_sma_checker (.*);
